FILE: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, operation codes and small helper functions for the rational
// fraction arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Significant bits of each operand field; upper bits are sign copies.
  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_WIDTH   = 32;
  localparam int OP_SHIFT      = FIELD_WIDTH - OPERAND_WIDTH;
  localparam int RES_WIDTH     = 64;

  // Operation codes carried in req_type.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_GT  = 3'd5;
  localparam logic [2:0] OP_EQ  = 3'd6;
  localparam logic [2:0] OP_NE  = 3'd7;

  // Input word: operation and two fractions.
  typedef struct packed {
    logic [2:0]                    req_type;
    logic signed [FIELD_WIDTH-1:0] a_num;
    logic signed [FIELD_WIDTH-1:0] a_den;
    logic signed [FIELD_WIDTH-1:0] b_num;
    logic signed [FIELD_WIDTH-1:0] b_den;
  } req_t;

  // Output word: reduced fraction or comparison flag.
  typedef struct packed {
    logic signed [RES_WIDTH-1:0] res_num;
    logic signed [RES_WIDTH-1:0] res_den;
    logic                        cmp_true;
  } rsp_t;

  // Keep the low OPERAND_WIDTH bits of a field and sign-extend them.
  function automatic logic signed [FIELD_WIDTH-1:0] sext_op(
    input logic [FIELD_WIDTH-1:0] v
  );
    logic signed [FIELD_WIDTH-1:0] t;
    t = $signed(v << OP_SHIFT);
    return t >>> OP_SHIFT;
  endfunction

  // Unsigned magnitude of a two's complement result word.
  function automatic logic [RES_WIDTH-1:0] mag(input logic [RES_WIDTH-1:0] x);
    return x[RES_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

FILE: design/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Signed operand multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module rau_mul
  import rau_pkg::*;
(
  input  logic                          clk_i,
  input  logic signed [FIELD_WIDTH-1:0] x_i,
  input  logic signed [FIELD_WIDTH-1:0] y_i,
  output logic signed [RES_WIDTH-1:0]   prod_o
);

  logic signed [RES_WIDTH-1:0] prod_q;

  // One product per cycle, registered before use.
  always_ff @(posedge clk_i) begin
    prod_q <= RES_WIDTH'(x_i) * RES_WIDTH'(y_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: design/rau_gcd.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit GCD engine
// Binary GCD of two unsigned magnitudes, one subtract or shift per cycle.
// ----------------------------------------------------------------------------
module rau_gcd
  import rau_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RES_WIDTH-1:0] a_i,
  input  logic [RES_WIDTH-1:0] b_i,
  output logic                 done_o,
  output logic [RES_WIDTH-1:0] gcd_o
);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_RUN   = 2'd1;
  localparam logic [1:0] G_SHIFT = 2'd2;

  localparam int KW = $clog2(RES_WIDTH);

  logic [1:0]           st_q, st_d;
  logic                 done_q, done_d;
  logic [RES_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]        k_q, k_d;
  logic                 a_ge_b;
  logic [RES_WIDTH-1:0] big, lit, diff;

  // Shared compare and subtract: larger minus smaller.
  assign a_ge_b = a_q >= b_q;
  assign big    = a_ge_b ? a_q : b_q;
  assign lit    = a_ge_b ? b_q : a_q;
  assign diff   = big - lit;

  // Step sequencer.
  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    case (st_q)
      G_IDLE: begin
        if (start_i) begin
          a_d  = a_i;
          b_d  = b_i;
          k_d  = '0;
          st_d = G_RUN;
        end
      end
      G_RUN: begin
        if (a_q == '0 || b_q == '0) begin
          // One side reached zero: the other holds the odd part.
          a_d  = a_q | b_q;
          st_d = G_SHIFT;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_ge_b) begin
          a_d = diff;
        end else begin
          b_d = diff;
        end
      end
      G_SHIFT: begin
        // Restore the common factors of two, one bit per cycle.
        if (k_q == '0) begin
          done_d = 1'b1;
          st_d   = G_IDLE;
        end else begin
          a_d = a_q << 1;
          k_d = k_q - 1'b1;
        end
      end
      default: st_d = G_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= G_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  assign done_o = done_q;
  assign gcd_o  = a_q;

endmodule

FILE: design/rau_div.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div
  import rau_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RES_WIDTH-1:0] dividend_i,
  input  logic [RES_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [RES_WIDTH-1:0] quot_o
);

  localparam int CW = $clog2(RES_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(RES_WIDTH - 1);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [RES_WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic [RES_WIDTH:0]   trial, diff;
  logic                 fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_q, quo_q[RES_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  // Control: count quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[RES_WIDTH-1:0] : trial[RES_WIDTH-1:0];
      quo_q <= {quo_q[RES_WIDTH-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: design/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two signed fractions and
// reduces arithmetic results by their greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one word
//   holding an operation code and two fractions. The output channel
//   (out_valid_o / out_ready_i / out_data_o) returns one word per input:
//   the reduced numerator and denominator, or a comparison flag.
//   One word is processed at a time; in_ready_o is high only while the
//   sequencer is idle. Three products come from one shared multiplier.
//   A comparison goes from the combine step straight to the output
//   step. Arithmetic results go on to the binary GCD engine (one subtract
//   or shift per cycle) and, when the GCD is nonzero, to two divisions
//   by the GCD through one shared restoring divider; a 0/0 result skips
//   the divisions and goes straight to the output step.
//   The result sits in an output register, so a new word is accepted while
//   the previous result waits. A stalled receiver holds the sequencer at its
//   last step until the output register frees up.
//   Reset clears the sequencer and the output valid; no stored state
//   survives between words.
// ----------------------------------------------------------------------------
module rational_arith_unit
  import rau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_MUL3  = 4'd3;
  localparam logic [3:0] S_MUL4  = 4'd4;
  localparam logic [3:0] S_COMB  = 4'd5;
  localparam logic [3:0] S_GCDST = 4'd6;
  localparam logic [3:0] S_GCD   = 4'd7;
  localparam logic [3:0] S_DIVN  = 4'd8;
  localparam logic [3:0] S_DIVD  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]                    state_q, state_d;
  logic [2:0]                    op_q;
  logic signed [FIELD_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [RES_WIDTH-1:0]   t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic signed [RES_WIDTH-1:0]   n_q, n_d, d_q, d_d;
  logic [RES_WIDTH-1:0]          k_q, k_d;
  logic                          cmp_q, cmp_d;
  logic                          out_valid_q;
  rsp_t                          out_q;
  logic                          accept, out_load;

  logic signed [FIELD_WIDTH-1:0] mul_x, mul_y;
  logic signed [RES_WIDTH-1:0]   prod;
  logic signed [RES_WIDTH-1:0]   an64, bn64, ad64;

  logic                          gcd_start, gcd_done;
  logic [RES_WIDTH-1:0]          gcd_res;
  logic                          div_start, div_done;
  logic [RES_WIDTH-1:0]          div_a, div_b, quot, quot_neg;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign an64 = RES_WIDTH'(an_q);
  assign bn64 = RES_WIDTH'(bn_q);
  assign ad64 = RES_WIDTH'(ad_q);

  // Operand pair for the shared multiplier at each step.
  always_comb begin
    mul_x = ad_q;
    mul_y = bd_q;
    case (state_q)
      S_MUL1: begin
        mul_x = an_q;
        mul_y = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      S_MUL2: begin
        mul_x = (op_q == OP_MUL) ? ad_q : bn_q;
        mul_y = (op_q == OP_MUL) ? bd_q : ad_q;
      end
      default: begin
        mul_x = ad_q;
        mul_y = bd_q;
      end
    endcase
  end

  rau_mul u_mul (
    .clk_i  (clk_i),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_o (prod)
  );

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (mag(n_q)),
    .b_i     (mag(d_q)),
    .done_o  (gcd_done),
    .gcd_o   (gcd_res)
  );

  // The divider first takes the numerator, then the denominator.
  assign div_a = (state_q == S_DIVN) ? mag(d_q) : mag(n_q);
  assign div_b = (state_q == S_GCD) ? gcd_res : k_q;

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign quot_neg = ~quot + 1'b1;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    n_d       = n_q;
    d_d       = d_q;
    k_d       = k_q;
    cmp_d     = cmp_q;
    gcd_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        t0_d    = prod;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        t1_d    = prod;
        state_d = S_MUL4;
      end
      S_MUL4: begin
        t2_d    = prod;
        state_d = S_COMB;
      end
      S_COMB: begin
        cmp_d   = 1'b0;
        state_d = S_GCDST;
        case (op_q)
          OP_ADD, OP_SUB: begin
            // Equal denominators skip the cross products.
            if (ad_q == bd_q) begin
              n_d = (op_q == OP_ADD) ? (an64 + bn64) : (an64 - bn64);
              d_d = ad64;
            end else begin
              n_d = (op_q == OP_ADD) ? (t0_q + t1_q) : (t0_q - t1_q);
              d_d = t2_q;
            end
          end
          OP_MUL, OP_DIV: begin
            n_d = t0_q;
            d_d = t1_q;
          end
          default: begin
            // Comparisons: cross products only, no reduction.
            n_d     = '0;
            d_d     = '0;
            state_d = S_OUT;
            case (op_q)
              OP_LT:   cmp_d = t0_q < t1_q;
              OP_GT:   cmp_d = t1_q < t0_q;
              OP_EQ:   cmp_d = t0_q == t1_q;
              default: cmp_d = t0_q != t1_q;
            endcase
          end
        endcase
      end
      S_GCDST: begin
        gcd_start = 1'b1;
        state_d   = S_GCD;
      end
      S_GCD: begin
        if (gcd_done) begin
          k_d = gcd_res;
          if (gcd_res == '0) begin
            // Both terms zero: leave the fraction unreduced.
            state_d = S_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIVN;
          end
        end
      end
      S_DIVN: begin
        if (div_done) begin
          n_d       = n_q[RES_WIDTH-1] ? quot_neg : quot;
          div_start = 1'b1;
          state_d   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          d_d     = d_q[RES_WIDTH-1] ? quot_neg : quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand capture and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i.req_type;
      an_q <= sext_op(in_data_i.a_num);
      ad_q <= sext_op(in_data_i.a_den);
      bn_q <= sext_op(in_data_i.b_num);
      bd_q <= sext_op(in_data_i.b_den);
    end
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    n_q   <= n_d;
    d_q   <= d_d;
    k_q   <= k_d;
    cmp_q <= cmp_d;
    if (out_load) begin
      out_q.res_num  <= n_q;
      out_q.res_den  <= d_q;
      out_q.cmp_true <= cmp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A comparison word carries a zero fraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cmp_true |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("comparison result with nonzero fraction");

  // The GCD engine only reports completion while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> state_q == S_GCD)
    else $error("GCD completion outside its wait step");

  // The divider only reports completion during a division step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVN || state_q == S_DIVD)
    else $error("divider completion outside a division step");

  // An accepted word starts the multiply sequence on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MUL1)
    else $error("accepted word did not start the sequence");

  // The output register is only loaded when it is free or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i)
    else $error("output word overwritten before it was taken");

endmodule
